[hdl/spq_pkg.sv]
package spq_pkg;

   localparam int DEPTH_DEFAULT     = 16;
   localparam int PRIO_BITS_DEFAULT = 8;

   localparam int KIND_W     = 1;
   localparam int CHAR_W     = 8;
   localparam int IN_PRIO_W  = 8;
   localparam int OUT_PRIO_W = 8;
   localparam int CAP_W      = 5;
   localparam int COUNT_W    = 5;
   localparam int STATUS_W   = 2;

   localparam logic [CAP_W-1:0] CAPACITY_RESET = 5'd16;

   localparam int REQ_DATA_W = 16;
   localparam int RSP_DATA_W = 32;

   typedef enum logic [KIND_W-1:0] {
      KIND_INSERT = 1'b0,
      KIND_REMOVE = 1'b1
   } kind_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK    = 2'd0,
      STATUS_FULL  = 2'd1,
      STATUS_EMPTY = 2'd2
   } status_type;

   typedef struct packed {
      logic insert_en;
      logic remove_en;
   } cmd_type;

endpackage

[hdl/sorted_priority_queue.sv]
// Sorted priority queue of (priority, character) entries held in a row of DEPTH
// cells, the smallest priority at the head and equal priorities in arrival order.
// A request beat with tuser low inserts the entry in tdata, and one with tuser
// high removes the head entry. Every cell compares the new priority with its own
// and shifts in the same cycle, so one request beat is taken every clock cycle
// unless a held response stalls it, and its response beat appears in the next
// cycle from an output register. Inserts into a full queue and removes from an
// empty one are answered with a rejection status and leave the queue unchanged.
module sorted_priority_queue #(
   parameter int DEPTH     = spq_pkg::DEPTH_DEFAULT,
   parameter int PRIO_BITS = spq_pkg::PRIO_BITS_DEFAULT
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   // in_prio[7:0], in_char[15:8]
   input  logic [spq_pkg::REQ_DATA_W-1:0] req_tdata,
   // kind[0]
   input  logic [spq_pkg::KIND_W-1:0]     req_tuser,
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   // status[1:0], out_prio[9:2], out_char[17:10], count[22:18], is_empty[23],
   // is_full[24], zero[31:25]
   output logic [spq_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input  logic                           csr_we,
   input  logic [spq_pkg::CAP_W-1:0]      csr_wdata
);
   import spq_pkg::*;

   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam int CMP_W = (CNT_W > CAP_W) ? CNT_W : CAP_W;

   logic [CAP_W-1:0] cap_ff;
   logic [CNT_W-1:0] occ_ff, occ_in;

   logic                rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;

   logic                   accept;
   logic [31:0]            prio_wide;
   logic [PRIO_BITS-1:0]   new_prio;
   logic [CHAR_W-1:0]      new_char;
   logic [CMP_W-1:0]       eff_cap;
   logic [CMP_W-1:0]       occ_ext;
   logic [CMP_W-1:0]       occ_next_ext;
   logic                   full_now;
   cmd_type                cmd;
   status_type             status;
   logic [31:0]            head_wide;
   logic [31:0]            count_wide;
   logic [OUT_PRIO_W-1:0]  out_prio;
   logic [CHAR_W-1:0]      out_char;

   logic [PRIO_BITS-1:0] cell_prio [DEPTH];
   logic [CHAR_W-1:0]    cell_char [DEPTH];
   logic                 cell_lt   [DEPTH];

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;

   assign prio_wide = 32'(req_tdata[IN_PRIO_W-1:0]);
   assign new_prio  = prio_wide[PRIO_BITS-1:0];
   assign new_char  = req_tdata[IN_PRIO_W +: CHAR_W];

   assign eff_cap  = (CMP_W'(cap_ff) > CMP_W'(DEPTH)) ? CMP_W'(DEPTH) : CMP_W'(cap_ff);
   assign occ_ext  = CMP_W'(occ_ff);
   assign full_now = occ_ext >= eff_cap;

   assign head_wide = 32'(cell_prio[0]);

   always_comb begin
      cmd          = '0;
      status       = STATUS_OK;
      occ_in       = occ_ff;
      out_prio     = '0;
      out_char     = '0;
      if (accept) begin
         case (kind_type'(req_tuser))
            KIND_INSERT: begin
               if (full_now) begin
                  status = STATUS_FULL;
               end else begin
                  cmd.insert_en = 1'b1;
                  occ_in        = occ_ff + CNT_W'(1);
               end
            end
            KIND_REMOVE: begin
               if (occ_ff == '0) begin
                  status = STATUS_EMPTY;
               end else begin
                  cmd.remove_en = 1'b1;
                  occ_in        = occ_ff - CNT_W'(1);
                  out_prio      = head_wide[OUT_PRIO_W-1:0];
                  out_char      = cell_char[0];
               end
            end
            default: begin
               status = STATUS_OK;
            end
         endcase
      end
      occ_next_ext = CMP_W'(occ_in);
      count_wide   = 32'(occ_in);
      rsp_data_in  = {7'd0,
                      occ_next_ext >= eff_cap,
                      occ_in == '0,
                      count_wide[COUNT_W-1:0],
                      out_char,
                      out_prio,
                      status};
      rsp_valid_in = accept || (rsp_valid_ff && !rsp_tready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff       <= CAPACITY_RESET;
         occ_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_we) begin
            cap_ff <= csr_wdata;
         end
         occ_ff       <= occ_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      if (accept) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic                 prev_lt;
      logic [PRIO_BITS-1:0] prev_prio, next_prio;
      logic [CHAR_W-1:0]    prev_char, next_char;

      if (i == 0) begin : g_first
         assign prev_lt   = 1'b0;
         assign prev_prio = cell_prio[i];
         assign prev_char = cell_char[i];
      end else begin : g_mid
         assign prev_lt   = cell_lt[i-1];
         assign prev_prio = cell_prio[i-1];
         assign prev_char = cell_char[i-1];
      end

      if (i == DEPTH - 1) begin : g_last
         assign next_prio = cell_prio[i];
         assign next_char = cell_char[i];
      end else begin : g_inner
         assign next_prio = cell_prio[i+1];
         assign next_char = cell_char[i+1];
      end

      spq_cell #(
         .PRIO_BITS(PRIO_BITS)
      ) u_cell (
         .clock     (clock),
         .cmd       (cmd),
         .new_prio  (new_prio),
         .new_char  (new_char),
         .valid     (CNT_W'(i) < occ_ff),
         .prev_lt   (prev_lt),
         .prev_prio (prev_prio),
         .prev_char (prev_char),
         .next_prio (next_prio),
         .next_char (next_char),
         .lt        (cell_lt[i]),
         .prio      (cell_prio[i]),
         .char_val  (cell_char[i])
      );
   end

endmodule

[hdl/spq_cell.sv]
module spq_cell #(
   parameter int PRIO_BITS = spq_pkg::PRIO_BITS_DEFAULT
) (
   input  logic                       clock,
   input  spq_pkg::cmd_type           cmd,
   input  logic [PRIO_BITS-1:0]       new_prio,
   input  logic [spq_pkg::CHAR_W-1:0] new_char,
   input  logic                       valid,
   input  logic                       prev_lt,
   input  logic [PRIO_BITS-1:0]       prev_prio,
   input  logic [spq_pkg::CHAR_W-1:0] prev_char,
   input  logic [PRIO_BITS-1:0]       next_prio,
   input  logic [spq_pkg::CHAR_W-1:0] next_char,
   output logic                       lt,
   output logic [PRIO_BITS-1:0]       prio,
   output logic [spq_pkg::CHAR_W-1:0] char_val
);
   import spq_pkg::*;

   logic [PRIO_BITS-1:0] prio_ff, prio_in;
   logic [CHAR_W-1:0]    char_ff, char_in;

   // An empty cell ranks behind any new entry.
   assign lt = !valid || (new_prio < prio_ff);

   always_comb begin
      prio_in = prio_ff;
      char_in = char_ff;
      if (cmd.insert_en) begin
         if (prev_lt) begin
            prio_in = prev_prio;
            char_in = prev_char;
         end else if (lt) begin
            prio_in = new_prio;
            char_in = new_char;
         end
      end else if (cmd.remove_en) begin
         prio_in = next_prio;
         char_in = next_char;
      end
   end

   always_ff @(posedge clock) begin
      prio_ff <= prio_in;
      char_ff <= char_in;
   end

   assign prio     = prio_ff;
   assign char_val = char_ff;

endmodule
